### design/pcle_pkg.sv
// Package: shared types, codes and sizes for the positional char list engine.
package pcle_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [2:0] FN_READ      = 3'd0;
   localparam logic [2:0] FN_OVERWRITE = 3'd1;
   localparam logic [2:0] FN_INSERT    = 3'd2;
   localparam logic [2:0] FN_REMOVE    = 3'd3;
   localparam logic [2:0] FN_SORTED    = 3'd4;
   localparam logic [2:0] FN_REVERSE   = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [2:0] func;
      logic [5:0] position;
      logic       at_end;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] read_value;
      logic [1:0] status;
      logic [6:0] count;
   } rsp_type;

   typedef enum logic [2:0] {
      CM_HOLD   = 3'd0,
      CM_WRITE  = 3'd1,
      CM_INSERT = 3'd2,
      CM_REMOVE = 3'd3,
      CM_SORTED = 3'd4,
      CM_ROTATE = 3'd5
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type    mode;
      logic [IDX_W-1:0] idx_a;
      logic [IDX_W-1:0] idx_b;
      logic [IDX_W-1:0] rd_idx;
      logic [CNT_W-1:0] length;
      logic [7:0]       value;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      S_IDLE    = 2'b01,
      S_REVERSE = 2'b10
   } ctrl_state_type;

endpackage

### design/pcle_cell.sv
// One list slot: holds a byte and updates from its neighbors per the broadcast command.
module pcle_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [pcle_pkg::IDX_W-1:0]     cell_index,
   input  pcle_pkg::cell_cmd_type         cmd,
   input  logic [7:0]                     left_data,
   input  logic [7:0]                     right_data,
   input  logic [7:0]                     bus_data,
   input  logic                           found_in,
   output logic                           found_out,
   output logic [7:0]                     tap,
   output logic [7:0]                     data
);

   logic [7:0]                 data_ff;
   logic [7:0]                 data_in;
   logic                       gt;
   logic [pcle_pkg::CNT_W-1:0] idx_ext;

   assign idx_ext   = pcle_pkg::CNT_W'(cell_index);
   assign gt        = data_ff > cmd.value;
   assign found_out = found_in | gt;
   assign tap       = (cell_index == cmd.rd_idx) ? data_ff : 8'd0;
   assign data      = data_ff;

   always_comb begin
      data_in = data_ff;
      case (cmd.mode)
         pcle_pkg::CM_WRITE: begin
            if (cell_index == cmd.idx_a) data_in = cmd.value;
         end
         pcle_pkg::CM_INSERT: begin
            if (cell_index > cmd.idx_a) data_in = left_data;
            else if (cell_index == cmd.idx_a) data_in = cmd.value;
         end
         pcle_pkg::CM_REMOVE: begin
            if (cell_index >= cmd.idx_a) data_in = right_data;
         end
         pcle_pkg::CM_SORTED: begin
            if (found_in) data_in = left_data;
            else if (gt || idx_ext == cmd.length) data_in = cmd.value;
         end
         pcle_pkg::CM_ROTATE: begin
            if (cell_index == cmd.idx_a) data_in = bus_data;
            else if (cell_index > cmd.idx_a && cell_index <= cmd.idx_b) data_in = left_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= 8'd0;
      end else begin
         data_ff <= data_in;
      end
   end

endmodule

### design/pcle_chain.sv
// Row of list cells with neighbor links, larger-than chain and read bus.
module pcle_chain (
   input  logic                   clock,
   input  logic                   reset,
   input  pcle_pkg::cell_cmd_type cmd,
   output logic [7:0]             read_data
);

   localparam int N = pcle_pkg::CAPACITY;

   logic [7:0] data  [N];
   logic [7:0] tap   [N];
   logic       found [N];
   logic [N-1:0] tap_bits [8];

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         for (int i = 0; i < N; i++) begin
            tap_bits[b][i] = tap[i][b];
         end
         read_data[b] = |tap_bits[b];
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic [7:0] left_d;
      logic [7:0] right_d;
      logic       f_in;

      if (i == 0) begin : g_first
         assign left_d = 8'd0;
         assign f_in   = 1'b0;
      end else begin : g_mid
         assign left_d = data[i-1];
         assign f_in   = found[i-1];
      end

      if (i == N - 1) begin : g_last
         assign right_d = 8'd0;
      end else begin : g_inner
         assign right_d = data[i+1];
      end

      pcle_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (pcle_pkg::IDX_W'(i)),
         .cmd        (cmd),
         .left_data  (left_d),
         .right_data (right_d),
         .bus_data   (read_data),
         .found_in   (f_in),
         .found_out  (found[i]),
         .tap        (tap[i]),
         .data       (data[i])
      );
   end

endmodule

### design/positional_char_list_engine_top.sv
// Top level: request decode, reverse sequencer, result queue and cell row.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_payload (req_type)
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_payload (rsp_type)
//
// Read, overwrite, insert, remove and sorted insert complete without entering the reverse sequencer.
// Reverse of n >= 2 entries runs the transfer, then n-1 rotate steps of
// the row with req_stall high; fewer entries leave the list as it is.
// Sorted insert position comes from a ripple compare along the row.
// Reset clears every cell and the count.
// A two-entry result queue lets one more transfer in while rsp is stalled.
module positional_char_list_engine_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pcle_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pcle_pkg::rsp_type rsp_payload
);

   localparam int CW = pcle_pkg::CNT_W;
   localparam int IW = pcle_pkg::IDX_W;
   localparam logic [CW-1:0] CAP = CW'(pcle_pkg::CAPACITY);

   pcle_pkg::ctrl_state_type state_ff, state_in;
   logic [CW-1:0]     length_ff, length_in;
   logic [IW-1:0]     step_ff, step_in;
   pcle_pkg::rsp_type out_ff, out_in, skid_ff, skid_in;
   logic              out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   pcle_pkg::cell_cmd_type cmd;
   pcle_pkg::rsp_type      res;
   logic [7:0]             read_data;
   logic                   accept, pop;
   logic [CW-1:0]          pos_ext, rm_pos, last_idx;

   assign req_stall   = (state_ff != pcle_pkg::S_IDLE) | skid_valid_ff;
   assign accept      = req_valid & ~req_stall;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;
   assign pop         = out_valid_ff & ~rsp_stall;

   assign pos_ext  = CW'(req_payload.position);
   assign last_idx = length_ff - CW'(1);
   assign rm_pos   = req_payload.at_end ? last_idx : pos_ext;

   always_comb begin
      state_in       = state_ff;
      length_in      = length_ff;
      step_in        = step_ff;
      cmd.mode       = pcle_pkg::CM_HOLD;
      cmd.idx_a      = req_payload.position;
      cmd.idx_b      = last_idx[IW-1:0];
      cmd.rd_idx     = req_payload.position;
      cmd.length     = length_ff;
      cmd.value      = req_payload.value;
      res.read_value = 8'd0;
      res.status     = pcle_pkg::ST_OK;

      if (state_ff == pcle_pkg::S_REVERSE) begin
         cmd.mode   = pcle_pkg::CM_ROTATE;
         cmd.idx_a  = step_ff;
         cmd.rd_idx = last_idx[IW-1:0];
         step_in    = step_ff + IW'(1);
         if (CW'(step_ff) == length_ff - CW'(2)) state_in = pcle_pkg::S_IDLE;
      end else if (accept) begin
         case (req_payload.func)
            pcle_pkg::FN_READ, pcle_pkg::FN_OVERWRITE: begin
               if (length_ff == '0) res.status = pcle_pkg::ST_EMPTY;
               else if (pos_ext >= length_ff) res.status = pcle_pkg::ST_RANGE;
               else if (req_payload.func == pcle_pkg::FN_READ) res.read_value = read_data;
               else cmd.mode = pcle_pkg::CM_WRITE;
            end
            pcle_pkg::FN_INSERT: begin
               if (length_ff == CAP) begin
                  res.status = pcle_pkg::ST_FULL;
               end else if (req_payload.at_end || length_ff == '0 || pos_ext == length_ff) begin
                  cmd.mode  = pcle_pkg::CM_INSERT;
                  cmd.idx_a = length_ff[IW-1:0];
                  length_in = length_ff + CW'(1);
               end else if (pos_ext > length_ff) begin
                  res.status = pcle_pkg::ST_RANGE;
               end else begin
                  cmd.mode  = pcle_pkg::CM_INSERT;
                  length_in = length_ff + CW'(1);
               end
            end
            pcle_pkg::FN_REMOVE: begin
               if (length_ff == '0) begin
                  res.status = pcle_pkg::ST_EMPTY;
               end else if (rm_pos >= length_ff) begin
                  res.status = pcle_pkg::ST_RANGE;
               end else begin
                  cmd.mode  = pcle_pkg::CM_REMOVE;
                  cmd.idx_a = rm_pos[IW-1:0];
                  length_in = length_ff - CW'(1);
               end
            end
            pcle_pkg::FN_SORTED: begin
               if (length_ff == CAP) begin
                  res.status = pcle_pkg::ST_FULL;
               end else begin
                  cmd.mode  = pcle_pkg::CM_SORTED;
                  length_in = length_ff + CW'(1);
               end
            end
            pcle_pkg::FN_REVERSE: begin
               if (length_ff >= CW'(2)) begin
                  state_in = pcle_pkg::S_REVERSE;
                  step_in  = '0;
               end
            end
            default: ;
         endcase
      end
      res.count = length_in;
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff && !pop) begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = res;
            out_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pcle_pkg::S_IDLE;
         length_ff     <= '0;
         step_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         length_ff     <= length_in;
         step_ff       <= step_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   pcle_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .read_data (read_data)
   );

endmodule

### design/pcle_checker.sv
// Checker: port-level properties of the list engine, bound to the top level.
module pcle_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input pcle_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pcle_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp transfer dropped while stalled");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.count <= 7'(pcle_pkg::CAPACITY))
      else $error("count above capacity");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != pcle_pkg::ST_OK |-> rsp_payload.read_value == 8'd0)
      else $error("read value set on error");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == pcle_pkg::ST_FULL
         |-> rsp_payload.count == 7'(pcle_pkg::CAPACITY))
      else $error("full status with list not full");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == pcle_pkg::ST_EMPTY |-> rsp_payload.count == 7'd0)
      else $error("empty status with entries present");

endmodule

bind positional_char_list_engine_top pcle_checker u_pcle_checker (.*);
